>>> rtl/sbsc_pkg.sv
// Package for the shadow bitmap store checker: request/response types,
// operation and status codes, state encoding and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package sbsc_pkg;

    localparam int unsigned REGION_BYTES_DEF = 1048576;
    localparam int unsigned GRAIN_LOG_DEF    = 2;

    localparam logic [1:0] OP_PROTECT   = 2'd0;
    localparam logic [1:0] OP_UNPROTECT = 2'd1;
    localparam logic [1:0] OP_STORE     = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_HIT    = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
        logic [20:0] length;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       checked;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_SPAN,
        S_READ,
        S_MOD
    } t_state;

endpackage

>>> rtl/shadow_bitmap_store_checker.sv
// Shadow bitmap store checker: one bit per grain of a guarded region, kept in
// a single-port shadow RAM with a registered read. Depends on sbsc_pkg.
//
// After reset the block clears the shadow RAM, one 32-bit word per cycle
// (SHADOW_WORDS words, 8192 at the defaults), with busy high. An item is
// taken when start is high and busy is low; its single result appears on
// o_rsp for one cycle with o_done and cannot be held off. A rejected request,
// an unknown operation, a store outside the armed window, a store with no
// grain in the region and a zero-length range give their result from S_EVAL
// without a RAM access; the block can take the next item in the same cycle
// as that result. Other items go through S_EVAL and S_SPAN, then walk the
// shadow words they cover with a read (S_READ) and a modify/write (S_MOD, a
// check only for a store) per word. A store stops at the first word holding a
// protected grain. The user must write region_base (i_cfg_we/i_cfg_wdata)
// only while no item is in progress; the block does not enforce this.
`timescale 1ns / 1ps

module shadow_bitmap_store_checker #(
    parameter int unsigned REGION_BYTES = sbsc_pkg::REGION_BYTES_DEF,
    parameter int unsigned GRAIN_LOG    = sbsc_pkg::GRAIN_LOG_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sbsc_pkg::t_req i_req,
    output logic          o_done,
    output sbsc_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata
);

    localparam int unsigned GRAIN_BYTES  = 1 << GRAIN_LOG;
    localparam int unsigned NUM_GRAINS   = (REGION_BYTES + GRAIN_BYTES - 1) >> GRAIN_LOG;
    localparam int unsigned SHADOW_WORDS = (NUM_GRAINS + 31) / 32;
    localparam int unsigned GW           = $clog2(NUM_GRAINS);
    localparam int unsigned AW           = $clog2(SHADOW_WORDS);
    localparam logic [31:0] GRAIN_MASK   = 32'(GRAIN_BYTES - 1);
    localparam logic [32:0] REGION_SIZE  = 33'(REGION_BYTES);
    localparam logic [AW-1:0] LAST_WORD  = AW'(SHADOW_WORDS - 1);

    sbsc_pkg::t_state r_state, n_state;
    sbsc_pkg::t_req   r_req, n_req;
    sbsc_pkg::t_rsp   r_rsp, n_rsp;

    logic          r_done, n_done;
    logic [32:0]   r_end, n_end;
    logic [31:0]   r_base, n_base;
    logic [32:0]   r_rend, n_rend;
    logic          r_armed, n_armed;
    logic [31:0]   r_wlo, n_wlo;
    logic [31:0]   r_whi, n_whi;
    logic [31:0]   r_lo, n_lo;
    logic [32:0]   r_hi, n_hi;
    logic [AW-1:0] r_wa, n_wa;
    logic [AW-1:0] r_w0, n_w0;
    logic [AW-1:0] r_wlast, n_wlast;
    logic [4:0]    r_b0, n_b0;
    logic [4:0]    r_b1, n_b1;
    logic [31:0]   r_rdata;

    logic [31:0] shadow_mem [SHADOW_WORDS];

    // memory port
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wd;

    // evaluation
    logic        misalign, out_range, range_bad, in_win, st_some, walk_go;
    logic [31:0] st_lo;
    logic [32:0] st_hi;

    // span
    logic [32:0] lo_off, hi_off, g0_full, g1_full;
    logic [GW-1:0] g0, g1;

    // word modify
    logic [4:0]  bit_lo, bit_hi;
    logic [31:0] word_mask;
    logic        word_hit, walk_end;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            shadow_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= shadow_mem[mem_addr];
        end
    end

    always_comb begin
        misalign  = ((r_req.address & GRAIN_MASK) != 32'd0)
                 || ((r_req.length & GRAIN_MASK[20:0]) != 21'd0);
        out_range = (r_req.address < r_base) || (r_end >= r_rend) || r_end[32];
        range_bad = misalign || out_range;
        in_win    = r_armed && (r_req.address >= r_wlo) && (r_req.address < r_whi);
        st_lo     = (r_req.address < r_base) ? r_base : r_req.address;
        st_hi     = (r_end > r_rend) ? r_rend : r_end;
        st_some   = ({1'b0, st_lo} < st_hi);
        case (r_req.operation)
            sbsc_pkg::OP_PROTECT,
            sbsc_pkg::OP_UNPROTECT: walk_go = !range_bad && (r_req.length != 21'd0);
            sbsc_pkg::OP_STORE:     walk_go = in_win && st_some;
            default:                walk_go = 1'b0;
        endcase

        lo_off  = {1'b0, r_lo} - {1'b0, r_base};
        hi_off  = r_hi - {1'b0, r_base} - 33'd1;
        g0_full = lo_off >> GRAIN_LOG;
        g1_full = hi_off >> GRAIN_LOG;
        g0      = g0_full[GW-1:0];
        g1      = g1_full[GW-1:0];

        bit_lo    = (r_wa == r_w0) ? r_b0 : 5'd0;
        bit_hi    = (r_wa == r_wlast) ? r_b1 : 5'd31;
        word_mask = (32'hFFFF_FFFF << bit_lo) & (32'hFFFF_FFFF >> (5'd31 - bit_hi));
        word_hit  = ((r_rdata & word_mask) != 32'd0);
        walk_end  = (r_wa == r_wlast)
                 || ((r_req.operation == sbsc_pkg::OP_STORE) && word_hit);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbsc_pkg::S_CLEAR: begin
                if (r_wa == LAST_WORD) begin
                    n_state = sbsc_pkg::S_IDLE;
                end
            end
            sbsc_pkg::S_IDLE: begin
                if (start) begin
                    n_state = sbsc_pkg::S_EVAL;
                end
            end
            sbsc_pkg::S_EVAL: begin
                n_state = walk_go ? sbsc_pkg::S_SPAN : sbsc_pkg::S_IDLE;
            end
            sbsc_pkg::S_SPAN: n_state = sbsc_pkg::S_READ;
            sbsc_pkg::S_READ: n_state = sbsc_pkg::S_MOD;
            sbsc_pkg::S_MOD: begin
                n_state = walk_end ? sbsc_pkg::S_IDLE : sbsc_pkg::S_READ;
            end
            default: n_state = sbsc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req    = r_req;
        n_end    = r_end;
        n_base   = r_base;
        n_rend   = r_rend;
        n_armed  = r_armed;
        n_wlo    = r_wlo;
        n_whi    = r_whi;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_wa     = r_wa;
        n_w0     = r_w0;
        n_wlast  = r_wlast;
        n_b0     = r_b0;
        n_b1     = r_b1;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_wa;
        mem_wd   = 32'd0;

        if (i_cfg_we) begin
            n_base = i_cfg_wdata;
            n_rend = {1'b0, i_cfg_wdata} + REGION_SIZE;
        end

        case (r_state)
            sbsc_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_wa   = r_wa + AW'(1);
            end
            sbsc_pkg::S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_end = {1'b0, i_req.address} + 33'(i_req.length);
                end
            end
            sbsc_pkg::S_EVAL: begin
                n_rsp = '{status: sbsc_pkg::ST_OK, checked: 1'b0};
                case (r_req.operation)
                    sbsc_pkg::OP_PROTECT, sbsc_pkg::OP_UNPROTECT: begin
                        n_lo = r_req.address;
                        n_hi = r_end;
                        if (range_bad) begin
                            n_rsp.status = sbsc_pkg::ST_REJECT;
                        end else if (r_req.operation == sbsc_pkg::OP_PROTECT) begin
                            n_armed = 1'b1;
                            if (!r_armed || r_req.address < r_wlo) begin
                                n_wlo = r_req.address;
                            end
                            if (!r_armed || r_end[31:0] > r_whi) begin
                                n_whi = r_end[31:0];
                            end
                        end
                    end
                    sbsc_pkg::OP_STORE: begin
                        n_lo          = st_lo;
                        n_hi          = st_hi;
                        n_rsp.checked = in_win;
                    end
                    default: n_rsp.status = sbsc_pkg::ST_REJECT;
                endcase
                n_done = !walk_go;
            end
            sbsc_pkg::S_SPAN: begin
                n_wa    = g0[AW+4:5];
                n_w0    = g0[AW+4:5];
                n_wlast = g1[AW+4:5];
                n_b0    = g0[4:0];
                n_b1    = g1[4:0];
            end
            sbsc_pkg::S_READ: begin
                mem_re = 1'b1;
            end
            sbsc_pkg::S_MOD: begin
                case (r_req.operation)
                    sbsc_pkg::OP_PROTECT: begin
                        mem_we = 1'b1;
                        mem_wd = r_rdata | word_mask;
                    end
                    sbsc_pkg::OP_UNPROTECT: begin
                        mem_we = 1'b1;
                        mem_wd = r_rdata & ~word_mask;
                    end
                    default: begin
                        if (word_hit) begin
                            n_armed      = 1'b0;
                            n_rsp.status = sbsc_pkg::ST_HIT;
                        end
                    end
                endcase
                n_wa   = r_wa + AW'(1);
                n_done = walk_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbsc_pkg::S_CLEAR;
            r_base  <= 32'd0;
            r_rend  <= REGION_SIZE;
            r_armed <= 1'b0;
            r_wlo   <= 32'd0;
            r_whi   <= 32'd0;
            r_wa    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_rend  <= n_rend;
            r_armed <= n_armed;
            r_wlo   <= n_wlo;
            r_whi   <= n_whi;
            r_wa    <= n_wa;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_end   <= n_end;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_w0    <= n_w0;
        r_wlast <= n_wlast;
        r_b0    <= n_b0;
        r_b1    <= n_b1;
        r_rsp   <= n_rsp;
    end

    assign busy   = (r_state != sbsc_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

>>> rtl/sbsc_checker.sv
// Port-level assertions for the shadow bitmap store checker, bound to the
// top level. Depends on sbsc_pkg and shadow_bitmap_store_checker.
`timescale 1ns / 1ps

module sbsc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input sbsc_pkg::t_rsp o_rsp
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("no clearing pass after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status != 2'd3)
                && !(o_rsp.checked && o_rsp.status == sbsc_pkg::ST_REJECT))
        else $error("illegal status or checked on a reject");

endmodule

bind shadow_bitmap_store_checker sbsc_checker u_sbsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
